// ===== rtl/slpd_pkg.sv =====
// Package for the short/long press detector: types, codes and reset constants.
`timescale 1ns / 1ps
`default_nettype none

package slpd_pkg;

  localparam int unsigned TimeW     = 64;
  localparam int unsigned MsW       = 16;
  localparam int unsigned ApbAddrW  = 3;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned InDataW   = 72;
  localparam int unsigned OutDataW  = 8;

  localparam logic [MsW-1:0] LongPressReset = 16'd550;
  localparam logic [MsW-1:0] PulseReset     = 16'd100;

  // Register index, taken from paddr bit 2 (word address)
  typedef enum logic {
    REG_LONG_PRESS = 1'b0,
    REG_PULSE      = 1'b1
  } reg_idx_e;

  typedef enum logic [1:0] {
    KIND_NONE  = 2'd0,
    KIND_SHORT = 2'd1,
    KIND_LONG  = 2'd2
  } pulse_kind_e;

  // One sampled input item
  typedef struct packed {
    logic             recenter_held;
    logic [TimeW-1:0] now_ms;
    logic             enabled;
    logic             button_down;
  } sample_t;

  // One result item
  typedef struct packed {
    logic recentered;
    logic long_pulse;
    logic short_pulse;
  } result_t;

endpackage : slpd_pkg

`default_nettype wire

// ===== rtl/short_long_press_detector.sv =====
// Top level of the short/long button press detector.
// An accepted item is held in the sample register, then in the result register,
// and leaves on m_axis. Throughput: one item per clock unless m_axis stalls;
// the state update and the 64-bit compares and saturating add sit in one
// combinational step between the sample register and the result register.
// Reset (rst_ni low, asynchronous): state cleared, registers back to
// long_press_ms = 550 and pulse_ms = 100, both pipeline stages empty.
`timescale 1ns / 1ps
`default_nettype none

module short_long_press_detector
  import slpd_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Sample channel
  input  wire logic                s_axis_tvalid_i,
  output      logic                s_axis_tready_o,
  // tdata: [0] button_down, [1] enabled, [65:2] now_ms, [66] recenter_held,
  // [71:67] ignored
  input  wire logic [InDataW-1:0]  s_axis_tdata_i,
  // Result channel
  output      logic                m_axis_tvalid_o,
  input  wire logic                m_axis_tready_i,
  // tdata: [0] short_pulse, [1] long_pulse, [2] recentered, [7:3] zero
  output      logic [OutDataW-1:0] m_axis_tdata_o,
  // Configuration port
  input  wire logic                psel_i,
  input  wire logic                penable_i,
  input  wire logic                pwrite_i,
  input  wire logic [ApbAddrW-1:0] paddr_i,
  input  wire logic [ApbDataW-1:0] pwdata_i,
  output      logic [ApbDataW-1:0] prdata_o,
  output      logic                pready_o
);

  // ---------------------------------------------------------------------
  // Configuration registers
  // ---------------------------------------------------------------------
  logic [MsW-1:0] long_press_q;
  logic [MsW-1:0] pulse_q;
  logic           cfg_wr;
  reg_idx_e       cfg_idx;

  assign pready_o = 1'b1;
  assign cfg_idx  = reg_idx_e'(paddr_i[2]);
  assign cfg_wr   = psel_i && penable_i && pwrite_i && pready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      long_press_q <= LongPressReset;
      pulse_q      <= PulseReset;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_LONG_PRESS: long_press_q <= pwdata_i[MsW-1:0];
        REG_PULSE:      pulse_q      <= pwdata_i[MsW-1:0];
        default:        ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_LONG_PRESS: prdata_o = {{(ApbDataW-MsW){1'b0}}, long_press_q};
      REG_PULSE:      prdata_o = {{(ApbDataW-MsW){1'b0}}, pulse_q};
      default:        prdata_o = '0;
    endcase
  end

  // ---------------------------------------------------------------------
  // Handshake: sample register -> result register. The sample stage moves
  // on whenever the result register is empty or being drained; the input
  // stalls only while both stages hold an item and the result waits on
  // m_axis.
  // ---------------------------------------------------------------------
  logic    smp_vld_q;
  sample_t smp_q;
  logic    res_vld_q;
  result_t res_q;
  logic    res_ready;
  logic    step;
  logic    s_fire;

  assign res_ready       = !res_vld_q || m_axis_tready_i;
  assign s_axis_tready_o = !smp_vld_q || res_ready;
  assign s_fire          = s_axis_tvalid_i && s_axis_tready_o;
  assign step            = smp_vld_q && res_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      smp_vld_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      smp_vld_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      smp_q <= sample_t'(s_axis_tdata_i[$bits(sample_t)-1:0]);
    end
  end

  // ---------------------------------------------------------------------
  // Detector state
  // ---------------------------------------------------------------------
  logic             holding_q,      holding_d;
  logic             long_done_q,    long_done_d;
  logic             need_release_q, need_release_d;
  pulse_kind_e      kind_q,         kind_d;
  logic [TimeW-1:0] prev_time_q,    prev_time_d;
  logic [TimeW-1:0] press_start_q,  press_start_d;
  logic [TimeW-1:0] deadline_q,     deadline_d;
  result_t          res_d;

  // Datapath terms, all in parallel off the sample register
  logic             time_back;
  logic [TimeW:0]   dl_sum;
  logic [TimeW-1:0] dl_sat;
  logic [TimeW-1:0] held_ms;
  logic             held_long;
  logic             dl_now_hit;   // fresh deadline already reached
  logic             old_dl_hit;
  logic             start;
  logic             fire_rec;
  logic             fire_long;
  logic             fire_short;
  logic             down;

  assign down       = smp_q.button_down;
  assign time_back  = smp_q.now_ms < prev_time_q;
  assign dl_sum     = {1'b0, smp_q.now_ms} + {{(TimeW+1-MsW){1'b0}}, pulse_q};
  assign dl_sat     = dl_sum[TimeW] ? {TimeW{1'b1}} : dl_sum[TimeW-1:0];
  assign held_ms    = smp_q.now_ms - press_start_q;
  assign held_long  = held_ms >= {{(TimeW-MsW){1'b0}}, long_press_q};
  // now + pulse (saturated) <= now only for a zero pulse or time at its top
  assign dl_now_hit = (pulse_q == '0) || (&smp_q.now_ms);
  assign old_dl_hit = smp_q.now_ms >= deadline_q;

  always_comb begin
    holding_d      = holding_q;
    long_done_d    = long_done_q;
    need_release_d = need_release_q;
    kind_d         = kind_q;
    prev_time_d    = smp_q.now_ms;
    press_start_d  = press_start_q;
    deadline_d     = deadline_q;
    res_d          = '0;
    start          = 1'b0;
    fire_rec       = 1'b0;
    fire_long      = 1'b0;
    fire_short     = 1'b0;

    if (!smp_q.enabled || time_back) begin
      // disabled or clock went backwards: drop everything, wait for release
      holding_d      = 1'b0;
      long_done_d    = 1'b0;
      kind_d         = KIND_NONE;
      need_release_d = down;
    end else if (need_release_q) begin
      if (!down) begin
        need_release_d = 1'b0;
      end
    end else begin
      start = down && !holding_q;
      if (start) begin
        holding_d     = 1'b1;
        long_done_d   = 1'b0;
        press_start_d = smp_q.now_ms;
      end
      // recenter takes the press before any long pulse can fire
      fire_rec  = down && (start || !long_done_q) && smp_q.recenter_held;
      fire_long = down && (start || !long_done_q) && !fire_rec &&
                  (start ? (long_press_q == '0) : held_long);
      fire_short = !down && holding_q && !long_done_q;

      if (fire_rec) begin
        long_done_d = 1'b1;
        kind_d      = KIND_NONE;
      end
      if (fire_long) begin
        long_done_d = 1'b1;
        kind_d      = KIND_LONG;
        deadline_d  = dl_sat;
      end
      if (!down && holding_q) begin
        holding_d = 1'b0;
        if (fire_short) begin
          kind_d     = KIND_SHORT;
          deadline_d = dl_sat;
        end
      end

      if ((fire_long || fire_short) ? dl_now_hit : old_dl_hit) begin
        kind_d = KIND_NONE;
      end

      res_d.short_pulse = (kind_d == KIND_SHORT);
      res_d.long_pulse  = (kind_d == KIND_LONG);
      res_d.recentered  = fire_rec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      holding_q      <= 1'b0;
      long_done_q    <= 1'b0;
      need_release_q <= 1'b0;
      kind_q         <= KIND_NONE;
      prev_time_q    <= '0;
      press_start_q  <= '0;
      deadline_q     <= '0;
    end else if (step) begin
      holding_q      <= holding_d;
      long_done_q    <= long_done_d;
      need_release_q <= need_release_d;
      kind_q         <= kind_d;
      prev_time_q    <= prev_time_d;
      press_start_q  <= press_start_d;
      deadline_q     <= deadline_d;
    end
  end

  // ---------------------------------------------------------------------
  // Result register
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
    end else if (res_ready) begin
      res_vld_q <= smp_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      res_q <= res_d;
    end
  end

  assign m_axis_tvalid_o = res_vld_q;
  assign m_axis_tdata_o  = {{(OutDataW-$bits(result_t)){1'b0}}, res_q};

endmodule : short_long_press_detector

`default_nettype wire

// ===== rtl/slpd_checker.sv =====
// Port-level checks for the short/long press detector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module slpd_checker
  import slpd_pkg::*;
(
  input wire logic                clk_i,
  input wire logic                rst_ni,
  input wire logic                s_axis_tready_o,
  input wire logic                m_axis_tvalid_o,
  input wire logic                m_axis_tready_i,
  input wire logic [OutDataW-1:0] m_axis_tdata_o,
  input wire logic                pready_o
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && !m_axis_tready_i |=> m_axis_tvalid_o && $stable(m_axis_tdata_o))
    else $error("result changed while stalled");

  // only one pulse kind at a time
  a_one_kind: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("short and long pulse together");

  // a recenter consumes the press: no pulse on that item
  a_rec_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && m_axis_tdata_o[2] |-> !m_axis_tdata_o[0] && !m_axis_tdata_o[1])
    else $error("pulse alongside recenter");

  // input only stalls behind a full, blocked result register
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s_axis_tready_o |-> m_axis_tvalid_o && !m_axis_tready_i)
    else $error("input stalled without output back-pressure");

  a_pready: assert property (@(posedge clk_i) disable iff (!rst_ni) pready_o)
    else $error("pready low");

endmodule : slpd_checker

bind short_long_press_detector slpd_checker u_slpd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .s_axis_tready_o (s_axis_tready_o),
  .m_axis_tvalid_o (m_axis_tvalid_o),
  .m_axis_tready_i (m_axis_tready_i),
  .m_axis_tdata_o  (m_axis_tdata_o),
  .pready_o        (pready_o)
);

`default_nettype wire
